// File: design/qslerp_pkg.sv
// ----------------------------------------------------------------------------
// qslerp_pkg
// Shared types, pipeline stage map and CORDIC angle table for the
// quaternion slerp unit.
// ----------------------------------------------------------------------------
package qslerp_pkg;

   // register map (word index taken from paddr[2])
   localparam logic REG_THRESHOLD = 1'b0;
   localparam logic [14:0] THRESHOLD_RESET = 15'd16;

   // fixed-point constants
   localparam logic [14:0] BLEND_ONE = 15'd16384;
   localparam int CORDIC_N = 30;
   localparam int SQRT_N = 29;
   localparam int QUO_N = 46;
   localparam int REM_W = 75;
   localparam logic signed [35:0] ROT_START = 36'sd652032874;

   // stage map
   localparam int ST_IN = 0;
   localparam int ST_PROD = 1;
   localparam int ST_DOT = 2;
   localparam int ST_SQR = 3;
   localparam int ST_SQ0 = 4;
   localparam int ST_VC0 = ST_SQ0 + SQRT_N;
   localparam int ST_OMT = ST_VC0 + CORDIC_N;
   localparam int ST_ANG = ST_OMT + 1;
   localparam int ST_RC0 = ST_ANG + 1;
   localparam int ST_DV0 = ST_RC0 + CORDIC_N;
   localparam int ST_WGT = ST_DV0 + QUO_N;
   localparam int ST_MUL = ST_WGT + 1;
   localparam int ST_OUT = ST_MUL + 1;
   localparam int NST = ST_OUT + 1;

   // data that travels with an item down the pipe as far as the weight stage
   typedef struct packed {
      logic [3:0][15:0] f;
      logic [3:0][16:0] g;
      logic [14:0]      t;
      logic             slerp;
      logic [27:0]      d;
      logic [28:0]      s;
   } side_type;

   // round(atan(2^-i) * 2^30)
   function automatic logic signed [32:0] atan_tab(input int i);
      logic signed [32:0] v;
      case (i)
         0: v = 33'sd843314857;
         1: v = 33'sd497837829;
         2: v = 33'sd263043837;
         3: v = 33'sd133525159;
         4: v = 33'sd67021687;
         5: v = 33'sd33543516;
         6: v = 33'sd16775851;
         7: v = 33'sd8388437;
         8: v = 33'sd4194283;
         9: v = 33'sd2097149;
         default: v = 33'sd1 <<< (30 - i);
      endcase
      return v;
   endfunction

endpackage

// File: design/quaternion_slerp_unit.sv
// ----------------------------------------------------------------------------
// quaternion_slerp_unit
// Throughput: one item per cycle; the whole pipe holds while a result stalls.
// The depth comes from the bit-serial square root, two 30-step CORDICs and a
// 46-step restoring divider, one step per stage.
// Reset clears all valid bits and sets linear_threshold to 16.
// ----------------------------------------------------------------------------
module quaternion_slerp_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_from_w,
   input  logic signed [15:0] req_from_x,
   input  logic signed [15:0] req_from_y,
   input  logic signed [15:0] req_from_z,
   input  logic signed [15:0] req_to_w,
   input  logic signed [15:0] req_to_x,
   input  logic signed [15:0] req_to_y,
   input  logic signed [15:0] req_to_z,
   input  logic [14:0]        req_blend,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_res_w,
   output logic signed [15:0] rsp_res_x,
   output logic signed [15:0] rsp_res_y,
   output logic signed [15:0] rsp_res_z,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   localparam int NST = qslerp_pkg::NST;
   localparam int CN = qslerp_pkg::CORDIC_N;
   localparam int SN = qslerp_pkg::SQRT_N;
   localparam int QN = qslerp_pkg::QUO_N;
   localparam int RW = qslerp_pkg::REM_W;

   // config register
   logic [14:0] thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= qslerp_pkg::THRESHOLD_RESET;
      end else if (psel && penable && pwrite && paddr[2] == qslerp_pkg::REG_THRESHOLD) begin
         thr_ff <= pwdata[14:0];
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr[2] == qslerp_pkg::REG_THRESHOLD) ? {17'b0, thr_ff} : 32'b0;

   // pipe control: everything moves together unless the output item stalls
   logic           adv;
   logic [NST-1:0] valid_ff;
   logic [NST-1:0] valid_in;

   assign adv = !(valid_ff[NST-1] && rsp_stall);
   assign req_stall = !adv;
   assign valid_in = {valid_ff[NST-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   qslerp_pkg::side_type side_ff [0:qslerp_pkg::ST_WGT];
   qslerp_pkg::side_type side_in [0:qslerp_pkg::ST_WGT];

   // input stage, blend clamped to one
   always_comb begin
      side_in[0] = '0;
      side_in[0].f[0] = req_from_w;
      side_in[0].f[1] = req_from_x;
      side_in[0].f[2] = req_from_y;
      side_in[0].f[3] = req_from_z;
      side_in[0].g[0] = {req_to_w[15], req_to_w};
      side_in[0].g[1] = {req_to_x[15], req_to_x};
      side_in[0].g[2] = {req_to_y[15], req_to_y};
      side_in[0].g[3] = {req_to_z[15], req_to_z};
      side_in[0].t = (req_blend > qslerp_pkg::BLEND_ONE) ? qslerp_pkg::BLEND_ONE : req_blend;
   end

   // component products
   logic signed [31:0] prod_ff [0:3];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 4; i++) begin
            prod_ff[i] <= $signed(side_ff[qslerp_pkg::ST_IN].f[i])
                        * $signed(side_ff[qslerp_pkg::ST_IN].g[i][15:0]);
         end
      end
   end

   // dot product, fold to positive, branch decision
   logic signed [33:0] dot;
   logic [33:0]        abs_dot;
   logic signed [34:0] gap;
   logic signed [34:0] thr_scaled;
   logic               dot_neg;
   logic               take_slerp;

   always_comb begin
      dot = 34'(prod_ff[0]) + 34'(prod_ff[1]) + 34'(prod_ff[2]) + 34'(prod_ff[3]);
      dot_neg = dot[33];
      abs_dot = dot_neg ? 34'(-dot) : 34'(dot);
      gap = (35'sd1 <<< 28) - $signed({1'b0, abs_dot});
      thr_scaled = $signed({6'b0, thr_ff, 14'b0});
      take_slerp = gap > thr_scaled;
   end

   // side data chain with the few stages that modify it
   logic [28:0] s_root;

   for (genvar k = 1; k <= qslerp_pkg::ST_WGT; k++) begin : g_side
      always_comb begin
         side_in[k] = side_ff[k-1];
         if (k == qslerp_pkg::ST_DOT) begin
            side_in[k].slerp = take_slerp;
            side_in[k].d = abs_dot[27:0];
            for (int i = 0; i < 4; i++) begin
               if (dot_neg) begin
                  side_in[k].g[i] = 17'(-$signed(side_ff[k-1].g[i]));
               end
            end
         end
         if (k == qslerp_pkg::ST_VC0) begin
            side_in[k].s = s_root;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k <= qslerp_pkg::ST_WGT; k++) begin
            side_ff[k] <= side_in[k];
         end
      end
   end

   // square of the folded dot product
   logic [55:0] sqm_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         sqm_ff <= side_ff[qslerp_pkg::ST_DOT].d * side_ff[qslerp_pkg::ST_DOT].d;
      end
   end

   // square root, one result bit per stage
   logic [56:0] sn_ff [0:SN-1];
   logic [57:0] sr_ff [0:SN-1];

   for (genvar k = 0; k < SN; k++) begin : g_sqrt
      localparam logic [57:0] BIT_V = 58'd1 << (56 - 2 * k);
      logic [56:0] n_cur;
      logic [57:0] r_cur;
      logic [57:0] trial;
      logic [56:0] n_nx;
      logic [57:0] r_nx;

      if (k == 0) begin : g_first
         assign n_cur = (57'd1 << 56) - {1'b0, sqm_ff};
         assign r_cur = '0;
      end else begin : g_next
         assign n_cur = sn_ff[k-1];
         assign r_cur = sr_ff[k-1];
      end

      always_comb begin
         trial = r_cur + BIT_V;
         if ({1'b0, n_cur} >= trial) begin
            n_nx = n_cur - trial[56:0];
            r_nx = (r_cur >> 1) + BIT_V;
         end else begin
            n_nx = n_cur;
            r_nx = r_cur >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sn_ff[k] <= n_nx;
            sr_ff[k] <= r_nx;
         end
      end
   end

   assign s_root = sr_ff[SN-1][28:0];

   // vectoring CORDIC: omega = atan2(s, dot)
   logic signed [35:0] vx_ff [0:CN-1];
   logic signed [35:0] vy_ff [0:CN-1];
   logic signed [32:0] vz_ff [0:CN-1];

   for (genvar i = 0; i < CN; i++) begin : g_vec
      localparam logic signed [32:0] ANG = qslerp_pkg::atan_tab(i);
      logic signed [35:0] x_cur;
      logic signed [35:0] y_cur;
      logic signed [32:0] z_cur;

      if (i == 0) begin : g_first
         assign x_cur = $signed({6'b0, side_ff[qslerp_pkg::ST_VC0-1].d, 2'b0});
         assign y_cur = $signed({5'b0, s_root, 2'b0});
         assign z_cur = '0;
      end else begin : g_next
         assign x_cur = vx_ff[i-1];
         assign y_cur = vy_ff[i-1];
         assign z_cur = vz_ff[i-1];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            if (!y_cur[35]) begin
               vx_ff[i] <= x_cur + (y_cur >>> i);
               vy_ff[i] <= y_cur - (x_cur >>> i);
               vz_ff[i] <= z_cur + ANG;
            end else begin
               vx_ff[i] <= x_cur - (y_cur >>> i);
               vy_ff[i] <= y_cur + (x_cur >>> i);
               vz_ff[i] <= z_cur - ANG;
            end
         end
      end
   end

   // split omega by the blend factor
   logic [31:0] om;
   logic [31:0] om_ff;
   logic [46:0] omt_ff;
   logic signed [34:0] a_ff [0:1];
   logic [32:0] a1_val;

   assign om = vz_ff[CN-1][32] ? 32'd0 : vz_ff[CN-1][31:0];

   always_ff @(posedge clock) begin
      if (adv) begin
         om_ff <= om;
         omt_ff <= om * side_ff[qslerp_pkg::ST_OMT-1].t;
      end
   end

   assign a1_val = 33'((omt_ff + 47'd8192) >> 14);

   always_ff @(posedge clock) begin
      if (adv) begin
         a_ff[1] <= $signed({2'b0, a1_val});
         a_ff[0] <= $signed({3'b0, om_ff}) - $signed({2'b0, a1_val});
      end
   end

   // rotation CORDIC, one lane per weight
   logic signed [35:0] rx_ff [0:1][0:CN-1];
   logic signed [35:0] ry_ff [0:1][0:CN-1];
   logic signed [34:0] rz_ff [0:1][0:CN-1];

   for (genvar l = 0; l < 2; l++) begin : g_rlane
      for (genvar i = 0; i < CN; i++) begin : g_rot
         localparam logic signed [34:0] ANG = 35'(qslerp_pkg::atan_tab(i));
         logic signed [35:0] x_cur;
         logic signed [35:0] y_cur;
         logic signed [34:0] z_cur;

         if (i == 0) begin : g_first
            assign x_cur = qslerp_pkg::ROT_START;
            assign y_cur = '0;
            assign z_cur = a_ff[l];
         end else begin : g_next
            assign x_cur = rx_ff[l][i-1];
            assign y_cur = ry_ff[l][i-1];
            assign z_cur = rz_ff[l][i-1];
         end

         always_ff @(posedge clock) begin
            if (adv) begin
               if (!z_cur[34]) begin
                  rx_ff[l][i] <= x_cur - (y_cur >>> i);
                  ry_ff[l][i] <= y_cur + (x_cur >>> i);
                  rz_ff[l][i] <= z_cur - ANG;
               end else begin
                  rx_ff[l][i] <= x_cur + (y_cur >>> i);
                  ry_ff[l][i] <= y_cur - (x_cur >>> i);
                  rz_ff[l][i] <= z_cur + ANG;
               end
            end
         end
      end
   end

   // restoring divide sin(a) * 2^28 / s, rounded half away from zero
   logic [RW-1:0] rem_ff [0:1][0:QN-1];
   logic [QN-1:0] quo_ff [0:1][0:QN-1];
   logic          qneg_ff [0:1][0:QN-1];

   for (genvar l = 0; l < 2; l++) begin : g_dlane
      for (genvar k = 0; k < QN; k++) begin : g_div
         localparam int SHD = QN - 1 - k;
         logic [RW-1:0] rem_cur;
         logic [QN-1:0] quo_cur;
         logic          neg_cur;
         logic [RW-1:0] dvs;
         logic          ge;

         if (k == 0) begin : g_first
            logic signed [35:0] y_in;
            logic [35:0]        mag;
            assign y_in = ry_ff[l][CN-1];
            assign neg_cur = y_in[35];
            assign mag = neg_cur ? 36'(-y_in) : 36'(y_in);
            assign rem_cur = ({39'b0, mag} << 28)
                           + RW'(side_ff[qslerp_pkg::ST_DV0-1].s >> 1);
            assign quo_cur = '0;
         end else begin : g_next
            assign rem_cur = rem_ff[l][k-1];
            assign quo_cur = quo_ff[l][k-1];
            assign neg_cur = qneg_ff[l][k-1];
         end

         assign dvs = RW'(side_ff[qslerp_pkg::ST_DV0+k-1].s) << SHD;
         assign ge = rem_cur >= dvs;

         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[l][k] <= ge ? (rem_cur - dvs) : rem_cur;
               quo_ff[l][k] <= {quo_cur[QN-2:0], ge};
               qneg_ff[l][k] <= neg_cur;
            end
         end
      end
   end

   // weight select: spherical or linear
   logic signed [47:0] w_ff [0:1];
   logic signed [47:0] w_in [0:1];

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         w_in[l] = qneg_ff[l][QN-1] ? -$signed({2'b0, quo_ff[l][QN-1]})
                                    : $signed({2'b0, quo_ff[l][QN-1]});
      end
      if (!side_ff[qslerp_pkg::ST_WGT-1].slerp) begin
         w_in[0] = $signed({17'b0, 15'(qslerp_pkg::BLEND_ONE - side_ff[qslerp_pkg::ST_WGT-1].t),
                            16'b0});
         w_in[1] = $signed({17'b0, side_ff[qslerp_pkg::ST_WGT-1].t, 16'b0});
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         w_ff[0] <= w_in[0];
         w_ff[1] <= w_in[1];
      end
   end

   // weighted components
   logic signed [63:0] p0_ff [0:3];
   logic signed [64:0] p1_ff [0:3];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 4; i++) begin
            p0_ff[i] <= w_ff[0] * $signed(side_ff[qslerp_pkg::ST_WGT].f[i]);
            p1_ff[i] <= w_ff[1] * $signed(side_ff[qslerp_pkg::ST_WGT].g[i]);
         end
      end
   end

   // sum, round, saturate
   logic signed [15:0] res_ff [0:3];
   logic signed [15:0] res_in [0:3];
   logic signed [65:0] acc [0:3];
   logic signed [35:0] shr [0:3];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         acc[i] = 66'(p0_ff[i]) + 66'(p1_ff[i]) + (66'sd1 <<< 29);
         shr[i] = 36'(acc[i] >>> 30);
         if (shr[i] > 36'sd32767) begin
            res_in[i] = 16'sh7fff;
         end else if (shr[i] < -36'sd32768) begin
            res_in[i] = 16'sh8000;
         end else begin
            res_in[i] = shr[i][15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 4; i++) begin
            res_ff[i] <= res_in[i];
         end
      end
   end

   assign rsp_valid = valid_ff[NST-1];
   assign rsp_res_w = res_ff[0];
   assign rsp_res_x = res_ff[1];
   assign rsp_res_y = res_ff[2];
   assign rsp_res_z = res_ff[3];

endmodule

// File: verif/tb_quaternion_slerp_unit.sv
// ----------------------------------------------------------------------------
// tb_quaternion_slerp_unit
// Self-checking bench for the quaternion slerp unit. Directed corner items
// are followed by random unit, near-parallel, opposite and raw quaternion
// pairs under several threshold settings. A bit-exact fixed-point model
// predicts each result. Both sides idle at random, and the result side holds
// off long enough once to back the pipe up into the input.
// ----------------------------------------------------------------------------
module tb_quaternion_slerp_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PIPE_DEPTH = 144;
   localparam int CYCLE_LIMIT = 600000;
   localparam int PHASE_ITEMS = 190;

   typedef struct {
      logic [3:0][15:0] f;
      logic [3:0][15:0] g;
      logic [14:0]      t;
   } quat_pair_type;

   // bit-exact slerp predictor and store of expected quaternions
   class slerp_board_type;
      longint           atan_q30[qslerp_pkg::CORDIC_N];
      logic [14:0]      threshold;
      logic [3:0][15:0] expected_q[$];
      int               errors;

      function new();
         bit [63:0] acc, term;
         int        k;
         atan_q30[0] = longint'((64'h3243F6A8885A308D + (64'd1 << 31)) >> 32);
         for (int i = 1; i < qslerp_pkg::CORDIC_N; i++) begin
            acc = 0;
            k = 0;
            for (int sh = i; sh <= 62; sh += 2 * i) begin
               term = (64'h4000_0000_0000_0000 >> sh) / (2 * k + 1);
               if (k % 2 == 1) acc -= term;
               else acc += term;
               k++;
            end
            atan_q30[i] = longint'((acc + (64'd1 << 31)) >> 32);
         end
         threshold = qslerp_pkg::THRESHOLD_RESET;
         errors = 0;
      endfunction

      function bit [63:0] int_sqrt(bit [63:0] n);
         bit [63:0] root, b;
         root = 0;
         b = 64'd1 << 62;
         while (b > n) b >>= 2;
         while (b != 0) begin
            if (n >= root + b) begin
               n -= root + b;
               root = (root >> 1) + b;
            end else begin
               root >>= 1;
            end
            b >>= 2;
         end
         return root;
      endfunction

      function longint vector_angle(longint x, longint y);
         longint z, nx;
         z = 0;
         for (int i = 0; i < qslerp_pkg::CORDIC_N; i++) begin
            if (y >= 0) begin
               nx = x + (y >>> i);
               y = y - (x >>> i);
               z += atan_q30[i];
            end else begin
               nx = x - (y >>> i);
               y = y + (x >>> i);
               z -= atan_q30[i];
            end
            x = nx;
         end
         return z;
      endfunction

      function longint rotate_sine(longint z);
         longint x, y, nx;
         x = 652032874;
         y = 0;
         for (int i = 0; i < qslerp_pkg::CORDIC_N; i++) begin
            if (z >= 0) begin
               nx = x - (y >>> i);
               y = y + (x >>> i);
               z -= atan_q30[i];
            end else begin
               nx = x + (y >>> i);
               y = y - (x >>> i);
               z += atan_q30[i];
            end
            x = nx;
         end
         return y;
      endfunction

      function longint round_div(longint num, longint den);
         if (num >= 0) return (num + den / 2) / den;
         return -((-num + den / 2) / den);
      endfunction

      function logic [15:0] round_sat(longint acc);
         bit [63:0] u;
         longint    r;
         u = acc + (64'd1 << 29) + (64'd1 << 62);
         r = longint'(u >> 30) - (longint'(1) << 32);
         if (r > 32767) r = 32767;
         if (r < -32768) r = -32768;
         return r[15:0];
      endfunction

      // work out the result of one accepted item
      function void note_item(quat_pair_type it);
         longint           f[4], g[4], dot, t, w0, w1, gap, s, om, a0, a1;
         logic [3:0][15:0] res;
         t = it.t;
         if (t > 16384) t = 16384;
         dot = 0;
         for (int i = 0; i < 4; i++) begin
            f[i] = longint'($signed(it.f[i]));
            g[i] = longint'($signed(it.g[i]));
            dot += f[i] * g[i];
         end
         if (dot < 0) begin
            dot = -dot;
            for (int i = 0; i < 4; i++) g[i] = -g[i];
         end
         w0 = (16384 - t) * 65536;
         w1 = t * 65536;
         gap = (longint'(1) << 28) - dot;
         if (gap > longint'(threshold) * 16384) begin
            s = longint'(int_sqrt((64'd1 << 56) - 64'(dot) * 64'(dot)));
            if (s != 0) begin
               om = vector_angle(dot * 4, s * 4);
               if (om < 0) om = 0;
               a1 = (om * t + 8192) >>> 14;
               a0 = om - a1;
               w0 = round_div(rotate_sine(a0) * (longint'(1) << 28), s);
               w1 = round_div(rotate_sine(a1) * (longint'(1) << 28), s);
            end
         end
         for (int i = 0; i < 4; i++) res[i] = round_sat(w0 * f[i] + w1 * g[i]);
         expected_q.push_back(res);
      endfunction

      task report(string what, int got, int want);
         errors++;
         $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
      endtask

      task check_result(logic [3:0][15:0] got);
         logic [3:0][15:0] want;
         string            names[4];
         names = '{"res_w", "res_x", "res_y", "res_z"};
         if (expected_q.size() == 0) begin
            report("unexpected item res_w", $signed(got[0]), 0);
         end else begin
            want = expected_q.pop_front();
            for (int i = 0; i < 4; i++)
               if (got[i] !== want[i])
                  report(names[i], $signed(got[i]), $signed(want[i]));
         end
      endtask
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [15:0] req_from_w = '0, req_from_x = '0, req_from_y = '0, req_from_z = '0;
   logic signed [15:0] req_to_w = '0, req_to_x = '0, req_to_y = '0, req_to_z = '0;
   logic [14:0]        req_blend = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [15:0] rsp_res_w, rsp_res_x, rsp_res_y, rsp_res_z;
   logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [2:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   slerp_board_type    board = new();
   bit                 calm = 1'b0;
   int                 hold_left = 0;
   int                 cycles = 0;

   quaternion_slerp_unit dut (.*);

   // clock
   initial begin
      forever #10 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // result-side stall bursts and the long hold-off
   initial begin
      int burst;
      burst = 0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (burst > 0) begin
            burst--;
            rsp_stall <= 1'b1;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            burst = $urandom_range(0, 17);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_result({rsp_res_z, rsp_res_y, rsp_res_x, rsp_res_w});
   end

   task csr_write(logic [31:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= 3'(qslerp_pkg::REG_THRESHOLD) << 2;
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      board.threshold = value[14:0];
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // offer one item, with an optional gap ahead of it
   task send_item(quat_pair_type it);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      req_valid <= 1'b1;
      {req_from_z, req_from_y, req_from_x, req_from_w} <= it.f;
      {req_to_z, req_to_y, req_to_x, req_to_w} <= it.g;
      req_blend <= it.t;
      do @(posedge clock); while (req_stall);
      board.note_item(it);
      @(negedge clock);
   endtask

   // wait until every expected item has come back
   task drain();
      while (board.expected_q.size() != 0) @(negedge clock);
   endtask

   function logic [3:0][15:0] unit_quat();
      real c[4], n;
      logic [3:0][15:0] q;
      n = 0.0;
      for (int i = 0; i < 4; i++) begin
         c[i] = real'(int'($urandom_range(0, 65535)) - 32768);
         n += c[i] * c[i];
      end
      if (n == 0.0) return 64'h0000_0000_0000_4000;
      n = $sqrt(n);
      for (int i = 0; i < 4; i++) q[i] = 16'($rtoi(c[i] * 16384.0 / n));
      return q;
   endfunction

   function quat_pair_type random_pair();
      quat_pair_type it;
      int            kind, spread;
      kind = $urandom_range(0, 99);
      it.f = unit_quat();
      if (kind < 45) begin
         it.g = unit_quat();
      end else if (kind < 75) begin
         // near-parallel, sometimes flipped, around the threshold
         spread = 1 << $urandom_range(0, 7);
         for (int i = 0; i < 4; i++)
            it.g[i] = 16'($signed(it.f[i]) + int'($urandom_range(0, 2 * spread)) - spread);
         if ($urandom_range(0, 1)) for (int i = 0; i < 4; i++) it.g[i] = -it.g[i];
      end else if (kind < 82) begin
         it.g = $urandom_range(0, 1) ? it.f : -it.f;
         for (int i = 0; i < 4; i++) it.g[i] = -$signed(it.f[i]);
         if ($urandom_range(0, 1)) it.g = it.f;
      end else begin
         it.f = {$urandom, $urandom};
         it.g = {$urandom, $urandom};
      end
      it.t = ($urandom_range(0, 6) == 0) ? 15'($urandom_range(0, 32767))
                                         : 15'($urandom_range(0, 16384));
      return it;
   endfunction

   // stimulus
   initial begin
      quat_pair_type  it;
      quat_pair_type  directed[$];
      logic [31:0]    settings[6];
      logic [15:0]    qn;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // corner items
      qn = 16'sd16384;
      directed.push_back('{64'h0000_0000_0000_4000, 64'h0000_0000_4000_0000, 15'd0});
      directed.push_back('{64'h0000_0000_0000_4000, 64'h0000_0000_4000_0000, 15'd16384});
      directed.push_back('{64'h0000_0000_0000_4000, 64'h0000_0000_4000_0000, 15'd8192});
      directed.push_back('{64'h0000_0000_0000_4000, 64'h0000_0000_4000_0000, 15'd32767});
      directed.push_back('{64'h0000_0000_0000_4000, 64'h0000_0000_0000_4000, 15'd5000});
      directed.push_back('{64'h0000_0000_0000_4000, {48'h0, -qn}, 15'd4096});
      directed.push_back('{64'h0000_0000_0000_4000, {-qn, 48'h0}, 15'd12000});
      directed.push_back('{{4{16'h7FFF}}, {4{16'h7FFF}}, 15'd8192});
      directed.push_back('{{4{16'h8000}}, {4{16'h8000}}, 15'd16384});
      directed.push_back('{{4{16'h7FFF}}, {4{16'h8000}}, 15'd1});
      directed.push_back('{64'h0, 64'h0, 15'd16383});
      directed.push_back('{64'h0, {4{16'h7FFF}}, 15'd16385});
      directed.push_back('{64'h2D41_0000_0000_2D41, 64'h2D41_0000_2D41_0000, 15'd10000});
      directed.push_back('{64'h0000_0000_0001_3FFF, 64'h0000_0000_0000_4000, 15'd8192});
      directed.push_back('{64'h2000_2000_2000_2000, 64'hE000_2000_E000_2000, 15'd3});
      directed.push_back('{64'h0000_0000_0000_4000, 64'h0000_0000_0100_3FFE, 15'd8192});
      directed.push_back('{{4{16'hFFFF}}, {4{16'h0001}}, 15'd16384});

      settings = '{32'd16, 32'd0, 32'd16384, 32'd32767, 32'($urandom_range(1, 600)), 32'd8};
      for (int p = 0; p < 6; p++) begin
         drain();
         repeat (PIPE_DEPTH + 8) @(negedge clock);
         csr_write(settings[p]);
         if (p == 1) hold_left = 700;
         if (p == 5) calm = 1'b1;
         if (p == 0) foreach (directed[i]) send_item(directed[i]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            it = random_pair();
            send_item(it);
         end
         req_valid <= 1'b0;
      end

      drain();
      repeat (PIPE_DEPTH + 20) @(posedge clock);
      if (board.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule

// File: sim.f
design/qslerp_pkg.sv
design/quaternion_slerp_unit.sv
verif/tb_quaternion_slerp_unit.sv
